// File: rtl/isswb_pkg.sv
// Shared types and constants for the identifier stack set with membership bitmap.
package isswb_pkg;

  // Widths of the request and response fields.
  localparam int IdFieldW    = 12;
  localparam int CountFieldW = 11;

  // Width of the bitmap epoch tag; a clear that wraps it starts a sweep.
  localparam int EpochW = 4;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindPop    = 2'd1,
    KindQuery  = 2'd2,
    KindClear  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [IdFieldW-1:0]  id;
  } req_t;

  typedef struct packed {
    logic [IdFieldW-1:0]    popped_id;
    logic                   is_member;
    status_e                status;
    logic [CountFieldW-1:0] count;
    logic                   empty_res;
  } rsp_t;

  // Bitmap access controls from the sequencer.
  typedef struct packed {
    logic rd;
    logic wr;
    logic wr_set;
    logic clear;
  } bm_ctl_t;

endpackage

// File: rtl/isswb_ram.sv
// Generic single-port synchronous RAM with registered read data.
module isswb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One access per cycle; read data holds while the port is idle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/isswb_bitmap.sv
// Membership bitmap: epoch-tagged bit memory with a clearing sweep on reset and epoch wrap.
module isswb_bitmap #(
  parameter int ID_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  isswb_pkg::bm_ctl_t     ctl_i,
  input  logic [ID_BITS-1:0]     addr_i,
  output logic                   member_o,
  output logic                   busy_o
);

  localparam int WordW = isswb_pkg::EpochW + 1;

  logic                          sweep_q, sweep_d;
  logic [ID_BITS-1:0]            sweep_addr_q, sweep_addr_d;
  logic [isswb_pkg::EpochW-1:0]  epoch_q, epoch_d;

  logic                ram_en;
  logic                ram_we;
  logic [ID_BITS-1:0]  ram_addr;
  logic [WordW-1:0]    ram_wdata;
  logic [WordW-1:0]    ram_rdata;

  // The sweep owns the port; otherwise the sequencer's read or write goes through.
  always_comb begin
    if (sweep_q) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = sweep_addr_q;
      ram_wdata = '0;
    end else begin
      ram_en    = ctl_i.rd | ctl_i.wr;
      ram_we    = ctl_i.wr;
      ram_addr  = addr_i;
      ram_wdata = {ctl_i.wr_set, epoch_q};
    end
  end

  isswb_ram #(
    .Width (WordW),
    .Depth (2 ** ID_BITS)
  ) u_bit_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // A clear moves to a fresh epoch; running out of epochs restarts the sweep.
  always_comb begin
    sweep_d      = sweep_q;
    sweep_addr_d = sweep_addr_q;
    epoch_d      = epoch_q;
    if (sweep_q) begin
      sweep_addr_d = sweep_addr_q + 1'b1;
      if (sweep_addr_q == '1) begin
        sweep_d = 1'b0;
      end
    end else if (ctl_i.clear) begin
      if (epoch_q == '1) begin
        sweep_d      = 1'b1;
        sweep_addr_d = '0;
        epoch_d      = '0;
      end else begin
        epoch_d = epoch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      epoch_q      <= '0;
    end else begin
      sweep_q      <= sweep_d;
      sweep_addr_q <= sweep_addr_d;
      epoch_q      <= epoch_d;
    end
  end

  // A bit counts only if it was set during the current epoch.
  assign member_o = ram_rdata[WordW-1] && (ram_rdata[WordW-2:0] == epoch_q);
  assign busy_o   = sweep_q;

endmodule

// File: rtl/id_stack_set_with_bitmap.sv
// Identifier set: LIFO stack of IDs in one RAM plus a membership bitmap in another.
// Response: built in the execute state from the registered reads, and registered once the output is free.
// A new request waits until the last one finishes (stack or bitmap read, then bitmap write-back).
// Reset: count and control clear at once; the bitmap sweep then clears all 2**ID_BITS words
// (4096 by default) with in_stall_o high, and every 16th clear repeats that sweep.
module id_stack_set_with_bitmap #(
  parameter int STACK_DEPTH = 1024,
  parameter int ID_BITS     = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  isswb_pkg::req_t   in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output isswb_pkg::rsp_t   out_o
);

  localparam int AddrW  = $clog2(STACK_DEPTH);
  localparam int CntW   = $clog2(STACK_DEPTH + 1);
  localparam int IdWide = (ID_BITS > isswb_pkg::IdFieldW) ? ID_BITS : isswb_pkg::IdFieldW;
  localparam int CntWide = (CntW > isswb_pkg::CountFieldW) ? CntW : isswb_pkg::CountFieldW;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                  state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  isswb_pkg::kind_e      kind_q;
  isswb_pkg::status_e    status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  isswb_pkg::rsp_t       out_q;
  isswb_pkg::rsp_t       rsp;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  full;
  logic                  empty;
  logic [CntW-1:0]       count_dec;
  logic [IdWide-1:0]     id_wide;
  logic [ID_BITS-1:0]    id_w;
  logic [IdWide-1:0]     popped_wide;
  logic [CntWide-1:0]    count_wide;

  logic                  stk_en;
  logic                  stk_we;
  logic [AddrW-1:0]      stk_addr;
  logic [ID_BITS-1:0]    stk_rdata;

  isswb_pkg::bm_ctl_t    bm_ctl;
  logic [ID_BITS-1:0]    bm_addr;
  logic                  bm_member;
  logic                  bm_busy;

  assign id_wide   = IdWide'(in_i.id);
  assign id_w      = id_wide[ID_BITS-1:0];
  assign full      = (count_q == CntW'(STACK_DEPTH));
  assign empty     = (count_q == '0);
  assign count_dec = count_q - 1'b1;

  assign in_stall_o = (state_q != StIdle) || bm_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == StExec) && out_free;

  // Stack port: push writes at the count, pop reads just below it.
  always_comb begin
    stk_en   = 1'b0;
    stk_we   = 1'b0;
    stk_addr = count_q[AddrW-1:0];
    if (accept && (in_i.kind == isswb_pkg::KindInsert) && !full) begin
      stk_en = 1'b1;
      stk_we = 1'b1;
    end else if (accept && (in_i.kind == isswb_pkg::KindPop) && !empty) begin
      stk_en   = 1'b1;
      stk_addr = count_dec[AddrW-1:0];
    end
  end

  isswb_ram #(
    .Width (ID_BITS),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .en_i    (stk_en),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (id_w),
    .rdata_o (stk_rdata)
  );

  // Bitmap port: set on push, read on query, new epoch on clear, clear the popped ID's bit when the pop finishes.
  always_comb begin
    bm_ctl  = '0;
    bm_addr = id_w;
    if (accept) begin
      case (in_i.kind)
        isswb_pkg::KindInsert: begin
          bm_ctl.wr     = !full;
          bm_ctl.wr_set = 1'b1;
        end
        isswb_pkg::KindQuery: begin
          bm_ctl.rd = 1'b1;
        end
        isswb_pkg::KindClear: begin
          bm_ctl.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (finish && (kind_q == isswb_pkg::KindPop) &&
                 (status_q == isswb_pkg::StatusOk)) begin
      bm_ctl.wr = 1'b1;
      bm_addr   = stk_rdata;
    end
  end

  isswb_bitmap #(
    .ID_BITS (ID_BITS)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (bm_ctl),
    .addr_i   (bm_addr),
    .member_o (bm_member),
    .busy_o   (bm_busy)
  );

  // Count and status settle at acceptance; the response is built in the following cycle.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      state_d  = StExec;
      status_d = isswb_pkg::StatusOk;
      case (in_i.kind)
        isswb_pkg::KindInsert: begin
          if (full) begin
            status_d = isswb_pkg::StatusFull;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        isswb_pkg::KindPop: begin
          if (empty) begin
            status_d = isswb_pkg::StatusEmpty;
          end else begin
            count_d = count_dec;
          end
        end
        isswb_pkg::KindClear: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end else if (finish) begin
      state_d = StIdle;
    end
  end

  // Response assembly from the registered memory reads.
  assign popped_wide = IdWide'(stk_rdata);
  assign count_wide  = CntWide'(count_q);

  always_comb begin
    rsp           = '0;
    rsp.status    = status_q;
    rsp.count     = count_wide[isswb_pkg::CountFieldW-1:0];
    rsp.empty_res = empty;
    if ((kind_q == isswb_pkg::KindPop) && (status_q == isswb_pkg::StatusOk)) begin
      rsp.popped_id = popped_wide[isswb_pkg::IdFieldW-1:0];
    end
    if (kind_q == isswb_pkg::KindQuery) begin
      rsp.is_member = bm_member;
    end
  end

  // Output register parts the request side from a stalled consumer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      status_q    <= isswb_pkg::StatusOk;
      kind_q      <= isswb_pkg::KindQuery;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        kind_q <= in_i.kind;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
